// ----- rtl/combining_dual_queue_matcher_unit_macros.svh -----
// assertion macros shared by the matcher rtl
`ifndef COMBINING_DUAL_QUEUE_MATCHER_UNIT_MACROS_SVH
`define COMBINING_DUAL_QUEUE_MATCHER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CDQM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdqm assertion failed");
// next-cycle implication
`define CDQM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdqm assertion failed");
`else
`define CDQM_ASSERT_IMP(label, clk, rst, ante, cons)
`define CDQM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/cdqm_pkg.sv -----
// shared types and constants of the combining dual-queue matcher
`timescale 1ns / 1ps

package cdqm_pkg;

   localparam int NUM_SLOTS_DEF   = 16;
   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int SLOT_W          = 4;
   localparam int DATA_W          = 32;

   // request kinds
   localparam logic [1:0] KIND_PRODUCE = 2'd0;
   localparam logic [1:0] KIND_CONSUME = 2'd1;
   localparam logic [1:0] KIND_COMBINE = 2'd2;

   // record status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_BUSY = 1'b1;

   typedef struct packed {
      logic [1:0]               req_type;
      logic [SLOT_W-1:0]        slot;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0]        done_slot;
      logic signed [DATA_W-1:0] data_out;
      logic                     completion;
      logic                     status;
      logic                     last_flag;
   } rsp_item_type;

   // data fifo control and status
   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_sts_type;

endpackage

// ----- rtl/cdqm_ram.sv -----
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps

module cdqm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/cdqm_data_fifo.sv -----
// circular data fifo: head and count pointers over a ram
`timescale 1ns / 1ps

module cdqm_data_fifo #(
   parameter int DEPTH = cdqm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cdqm_pkg::fifo_ctl_type        ctl,
   input  logic [cdqm_pkg::DATA_W-1:0]   wr_data,
   output cdqm_pkg::fifo_sts_type        sts,
   output logic [cdqm_pkg::DATA_W-1:0]   rd_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW:0]   tail_sum;
   logic [PW-1:0] tail;

   // tail = (head + count) mod depth, sum stays below twice the depth
   always_comb begin
      tail_sum = (PW + 1)'(head_ff) + (PW + 1)'(count_ff);
      if (tail_sum >= (PW + 1)'(DEPTH)) begin
         tail_sum = tail_sum - (PW + 1)'(DEPTH);
      end
      tail = tail_sum[PW-1:0];
   end

   // pointer updates
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == CW'(DEPTH));

   cdqm_ram #(
      .WIDTH(cdqm_pkg::DATA_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ctl.push),
      .wr_addr(tail),
      .wr_data(wr_data),
      .rd_en  (ctl.pop),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

endmodule

// ----- rtl/combining_dual_queue_matcher_unit.sv -----
// combining dual-queue matcher: request slots, combine sequencer, result staging
//
// Clients post produce or consume requests into slots on the req_ channel and
// run a combining pass with a combine transaction. Every transaction gives one
// or more result transactions on the rsp_ channel; last_flag marks the final one.
// A post's record goes through the staging register into the output register.
// A combine scans every slot (16 by default) and matches waiting consumers;
// the sequencer visits one slot per cycle unless a match or a stalled record
// holds it; each match pops the stack, then takes the registered fifo ram read.
// One transaction is worked on at a time; req_ready is high only while the
// sequencer is idle, and a finished result may still sit in the output
// register then. Records are staged one deep so the final one can be marked.
// When the receiver stalls, the pass holds at the next record until the
// output register frees up; nothing is dropped.
// Reset (synchronous, active high) clears all pending slots, the fifo and
// stack pointers and the output register; no clearing pass is needed.
`timescale 1ns / 1ps
`include "combining_dual_queue_matcher_unit_macros.svh"

module combining_dual_queue_matcher_unit #(
   parameter int NUM_SLOTS   = cdqm_pkg::NUM_SLOTS_DEF,
   parameter int QUEUE_DEPTH = cdqm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  cdqm_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output cdqm_pkg::rsp_item_type rsp_data
);

   localparam int SW = cdqm_pkg::SLOT_W;
   localparam int DW = cdqm_pkg::DATA_W;
   localparam int SLOTS_USED = (NUM_SLOTS < (1 << SW)) ? NUM_SLOTS : (1 << SW);
   localparam int TW = (SLOTS_USED > 1) ? $clog2(SLOTS_USED) : 1;
   localparam int CW = $clog2(SLOTS_USED + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EVAL   = 5'b00010,
      S_MATCH  = 5'b00100,
      S_MDATA  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [SLOTS_USED-1:0] pending_ff, pending_in;
   logic [SLOTS_USED-1:0] consumer_ff, consumer_in;
   logic signed [DW-1:0] value_ff [SLOTS_USED];
   logic signed [DW-1:0] value_in [SLOTS_USED];
   logic [SW-1:0] stack_ff [SLOTS_USED];
   logic [SW-1:0] stack_in [SLOTS_USED];
   logic [CW-1:0] stack_cnt_ff, stack_cnt_in;
   logic [SW-1:0] cons_ff, cons_in;
   cdqm_pkg::rsp_item_type stage_ff, stage_in;
   logic stage_vld_ff, stage_vld_in;
   cdqm_pkg::rsp_item_type out_ff, out_in;
   logic out_vld_ff, out_vld_in;

   cdqm_pkg::fifo_ctl_type fifo_ctl;
   cdqm_pkg::fifo_sts_type fifo_sts;
   logic [DW-1:0] fifo_rd_data;
   logic signed [DW-1:0] fifo_wr_data;

   logic out_free, can_emit, emit, out_load, last_slot;
   cdqm_pkg::rsp_item_type emit_rec, out_rec;
   logic [TW-1:0] cur, post_idx, top_idx;
   logic [CW-1:0] pop_cnt;
   logic [SW-1:0] top_slot;
   logic busy, prod, cons, match;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign can_emit  = !stage_vld_ff || out_free;
   assign cur       = idx_ff[TW-1:0];
   assign post_idx  = req_data.slot[TW-1:0];
   assign pop_cnt   = stack_cnt_ff - 1'b1;
   assign top_idx   = pop_cnt[TW-1:0];
   assign top_slot  = stack_ff[top_idx];
   assign last_slot = (idx_ff == SW'(SLOTS_USED - 1));
   assign fifo_wr_data = value_ff[cur];

   // sequencer: posts, slot scan and consumer matching
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pending_in   = pending_ff;
      consumer_in  = consumer_ff;
      value_in     = value_ff;
      stack_in     = stack_ff;
      stack_cnt_in = stack_cnt_ff;
      cons_in      = cons_ff;
      stage_in     = stage_ff;
      stage_vld_in = stage_vld_ff;
      fifo_ctl     = '0;
      emit         = 1'b0;
      emit_rec     = '0;
      out_load     = 1'b0;
      out_rec      = '0;
      busy         = 1'b0;
      prod         = 1'b0;
      cons         = 1'b0;
      match        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type inside {cdqm_pkg::KIND_PRODUCE,
                                             cdqm_pkg::KIND_CONSUME}) begin
                  busy = ({1'b0, req_data.slot} >= (SW + 1)'(SLOTS_USED)) ||
                         pending_ff[post_idx];
                  if (!busy) begin
                     pending_in[post_idx]  = 1'b1;
                     consumer_in[post_idx] = (req_data.req_type == cdqm_pkg::KIND_CONSUME);
                     value_in[post_idx]    = req_data.value;
                  end
                  stage_in           = '0;
                  stage_in.done_slot = req_data.slot;
                  stage_in.status    = busy ? cdqm_pkg::STATUS_BUSY : cdqm_pkg::STATUS_OK;
                  stage_vld_in       = 1'b1;
                  state_in           = S_FINISH;
               end else if (req_data.req_type == cdqm_pkg::KIND_COMBINE) begin
                  stack_cnt_in = '0;
                  idx_in       = '0;
                  state_in     = S_EVAL;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_EVAL: begin
            prod = pending_ff[cur] && !consumer_ff[cur] && !fifo_sts.full;
            cons = pending_ff[cur] && consumer_ff[cur];
            if (!prod || can_emit) begin
               // producer completes into the fifo
               if (prod) begin
                  fifo_ctl.push       = 1'b1;
                  pending_in[cur]     = 1'b0;
                  emit                = 1'b1;
                  emit_rec.done_slot  = idx_ff;
                  emit_rec.completion = 1'b1;
               end
               // consumer waits on the stack
               if (cons) begin
                  stack_in[stack_cnt_ff[TW-1:0]] = idx_ff;
                  stack_cnt_in = stack_cnt_ff + 1'b1;
               end
               match = ((stack_cnt_ff != '0) || cons) && (!fifo_sts.empty || prod);
               if (match) begin
                  state_in = S_MATCH;
               end else if (last_slot) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_MATCH: begin
            // pop top consumer and read the fifo head
            cons_in      = top_slot;
            stack_cnt_in = pop_cnt;
            pending_in[top_slot[TW-1:0]]  = 1'b0;
            consumer_in[top_slot[TW-1:0]] = 1'b0;
            fifo_ctl.pop = 1'b1;
            state_in     = S_MDATA;
         end
         S_MDATA: begin
            if (can_emit) begin
               emit                = 1'b1;
               emit_rec.done_slot  = cons_ff;
               emit_rec.data_out   = fifo_rd_data;
               emit_rec.completion = 1'b1;
               if (last_slot) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_EVAL;
               end
            end
         end
         S_FINISH: begin
            // final record, or an empty one when nothing completed
            if (out_free) begin
               out_load          = 1'b1;
               out_rec           = stage_vld_ff ? stage_ff : '0;
               out_rec.last_flag = 1'b1;
               stage_vld_in      = 1'b0;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // staging: a new record pushes the held one out as not last
      if (emit) begin
         if (stage_vld_ff) begin
            out_load = 1'b1;
            out_rec  = stage_ff;
         end
         stage_in     = emit_rec;
         stage_vld_in = 1'b1;
      end
   end

   // output register
   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_in     = out_rec;
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         pending_ff   <= '0;
         consumer_ff  <= '0;
         stack_cnt_ff <= '0;
         stage_vld_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         pending_ff   <= pending_in;
         consumer_ff  <= consumer_in;
         stack_cnt_ff <= stack_cnt_in;
         stage_vld_ff <= stage_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff <= value_in;
      stack_ff <= stack_in;
      cons_ff  <= cons_in;
      stage_ff <= stage_in;
      out_ff   <= out_in;
   end

   cdqm_data_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock  (clock),
      .reset  (reset),
      .ctl    (fifo_ctl),
      .wr_data(fifo_wr_data),
      .sts    (fifo_sts),
      .rd_data(fifo_rd_data)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // checks on sequencer and fifo use
   `CDQM_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != S_IDLE)
   `CDQM_ASSERT_IMP(a_match_has_pair, clock, reset, state_ff == S_MATCH, (stack_cnt_ff != '0) && !fifo_sts.empty)
   `CDQM_ASSERT_NXT(a_match_then_data, clock, reset, state_ff == S_MATCH, state_ff == S_MDATA)
   `CDQM_ASSERT_IMP(a_no_push_full, clock, reset, fifo_ctl.push, !fifo_sts.full)
   `CDQM_ASSERT_IMP(a_idle_stage_empty, clock, reset, state_ff == S_IDLE, !stage_vld_ff)

endmodule

// ----- sim/combining_dual_queue_matcher_unit_tb.sv -----
// self-checking testbench for the combining dual-queue matcher
`timescale 1ns / 1ps

module combining_dual_queue_matcher_unit_tb;

   // request kind that the block ignores
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam int NUM_SLOTS   = cdqm_pkg::NUM_SLOTS_DEF;
   localparam int QUEUE_DEPTH = cdqm_pkg::QUEUE_DEPTH_DEF;
   localparam int DATA_W      = cdqm_pkg::DATA_W;
   localparam int SLOT_W      = cdqm_pkg::SLOT_W;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 80;
   localparam int ITEM_CAP    = 1024;
   localparam int REC_CAP     = 4096;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   cdqm_pkg::req_item_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   cdqm_pkg::rsp_item_type rsp_data;

   // transactions waiting to be driven and records still owed by the block
   cdqm_pkg::req_item_type pending_items[ITEM_CAP];
   int                     pend_wr = 0;
   int                     pend_rd = 0;
   cdqm_pkg::rsp_item_type expected_records[REC_CAP];
   int                     exp_wr = 0;
   int                     exp_rd = 0;

   // shadow state of the matcher
   logic                     slot_pending[NUM_SLOTS];
   logic                     slot_is_consumer[NUM_SLOTS];
   logic [DATA_W-1:0]        slot_value[NUM_SLOTS];
   logic [DATA_W-1:0]        fifo_words[QUEUE_DEPTH];
   logic [5:0]               fifo_head;
   logic [6:0]               fifo_count;

   // traffic shaping shared between the sequence and the driver/monitor
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_served   = 0;
   int stall_left     = 0;
   int error_count    = 0;
   int quiet_cycles   = 0;

   combining_dual_queue_matcher_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // queue one request transaction for the driver
   function automatic void add_item(logic [1:0] kind, logic [SLOT_W-1:0] slot,
                                    logic [DATA_W-1:0] value);
      cdqm_pkg::req_item_type item;
      item.req_type = kind;
      item.slot     = slot;
      item.value    = value;
      if (pend_wr < ITEM_CAP) begin
         pending_items[pend_wr] = item;
         pend_wr++;
      end
   endfunction

   // record one expected result transaction
   function automatic void expect_record(cdqm_pkg::rsp_item_type rec);
      if (exp_wr < REC_CAP) begin
         expected_records[exp_wr] = rec;
         exp_wr++;
      end
   endfunction

   // work out the records that one accepted transaction produces
   function automatic void match_requests(cdqm_pkg::req_item_type item);
      cdqm_pkg::rsp_item_type recs[17];
      int                     rec_count;
      cdqm_pkg::rsp_item_type rec;
      logic [3:0]             waiting_slots[16];
      int                     waiting_count;
      logic [3:0]             taker;
      logic [5:0]             tail;
      logic [DATA_W-1:0]      word;
      rec = '0;
      rec_count = 0;
      if (item.req_type == cdqm_pkg::KIND_PRODUCE ||
          item.req_type == cdqm_pkg::KIND_CONSUME) begin
         rec.done_slot = item.slot;
         rec.status    = cdqm_pkg::STATUS_OK;
         if (slot_pending[item.slot]) begin
            rec.status = cdqm_pkg::STATUS_BUSY;
         end else begin
            slot_pending[item.slot]     = 1'b1;
            slot_is_consumer[item.slot] = (item.req_type == cdqm_pkg::KIND_CONSUME);
            slot_value[item.slot]       = (item.req_type == cdqm_pkg::KIND_CONSUME) ?
                                          '0 : item.value;
         end
         recs[rec_count] = rec;
         rec_count++;
      end else if (item.req_type == cdqm_pkg::KIND_COMBINE) begin
         // stack starts empty on every pass
         waiting_count = 0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_pending[s]) begin
               if (!slot_is_consumer[s]) begin
                  // producer stays pending when the fifo is full
                  if (fifo_count < QUEUE_DEPTH) begin
                     tail = fifo_head + fifo_count[5:0];
                     fifo_words[tail] = slot_value[s];
                     fifo_count++;
                     slot_pending[s] = 1'b0;
                     slot_value[s]   = '0;
                     rec = '0;
                     rec.done_slot  = s[3:0];
                     rec.completion = 1'b1;
                     recs[rec_count] = rec;
                     rec_count++;
                  end
               end else begin
                  waiting_slots[waiting_count] = s[3:0];
                  waiting_count++;
               end
            end
            // hand fifo head to the most recent consumer
            while (waiting_count > 0 && fifo_count > 0) begin
               waiting_count--;
               taker = waiting_slots[waiting_count];
               word  = fifo_words[fifo_head];
               fifo_head++;
               fifo_count--;
               slot_pending[taker]     = 1'b0;
               slot_is_consumer[taker] = 1'b0;
               slot_value[taker]       = word;
               rec = '0;
               rec.done_slot  = taker;
               rec.data_out   = word;
               rec.completion = 1'b1;
               recs[rec_count] = rec;
               rec_count++;
            end
         end
      end
      // pass with no completions or ignored kind gives one empty record
      if (rec_count == 0) begin
         recs[0] = '0;
         rec_count = 1;
      end
      recs[rec_count-1].last_flag = 1'b1;
      for (int i = 0; i < rec_count; i++) expect_record(recs[i]);
   endfunction

   function automatic void report_error(string what, cdqm_pkg::rsp_item_type want,
                                        cdqm_pkg::rsp_item_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t %s: expected slot %0d data %h comp %b status %b last %b",
                  $realtime, what, want.done_slot, want.data_out, want.completion,
                  want.status, want.last_flag);
         $display("%0t %s: actual   slot %0d data %h comp %b status %b last %b",
                  $realtime, what, got.done_slot, got.data_out, got.completion,
                  got.status, got.last_flag);
      end
   endfunction

   // one round of posts to random slots closed by a combine, with some noise
   function automatic int add_round(int produce_pct);
      int posts;
      int count;
      posts = $urandom_range(16, 6);
      count = 0;
      for (int i = 0; i < posts; i++) begin
         if ($urandom_range(99) < 8) begin
            add_item(2'($urandom_range(3)), 4'($urandom), $urandom);
            count++;
         end else begin
            add_item(($urandom_range(99) < produce_pct) ? cdqm_pkg::KIND_PRODUCE :
                     cdqm_pkg::KIND_CONSUME, 4'($urandom_range(15)), $urandom);
            count++;
         end
      end
      add_item(cdqm_pkg::KIND_COMBINE, 4'($urandom), $urandom);
      return count + 1;
   endfunction

   // driver: accept on handshake, then offer the next transaction or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) match_requests(req_data);
         if (!req_valid || req_ready) begin
            if (pend_wr > pend_rd && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_items[pend_rd];
               pend_rd++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each record, then choose ready for the next cycle
   always @(posedge clock) begin
      cdqm_pkg::rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (exp_rd >= exp_wr) begin
               report_error("unexpected record", '0, rsp_data);
            end else begin
               want = expected_records[exp_rd];
               exp_rd++;
               if (rsp_data.done_slot !== want.done_slot ||
                   rsp_data.data_out !== want.data_out ||
                   rsp_data.completion !== want.completion ||
                   rsp_data.status !== want.status ||
                   rsp_data.last_flag !== want.last_flag)
                  report_error("record mismatch", want, rsp_data);
            end
         end
         // long hold-off so the block backs up into its input
         if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (holds_asked > holds_served) begin
            rsp_ready    <= 1'b0;
            stall_left   <= HOLD_CYCLES;
            holds_served <= holds_served + 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      int send_pct[4];
      int recv_pct[4];
      int produce_pct[4];
      int queued;
      send_pct    = '{0, 49, 0, 38};
      recv_pct    = '{0, 0, 49, 38};
      produce_pct = '{90, 90, 30, 30};
      for (int s = 0; s < NUM_SLOTS; s++) begin
         slot_pending[s]     = 1'b0;
         slot_is_consumer[s] = 1'b0;
         slot_value[s]       = '0;
      end
      fifo_head  = '0;
      fifo_count = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty pass, ignored kind, busy posts, lifo matching, extremes
      add_item(cdqm_pkg::KIND_COMBINE, 4'd0, 32'h0);
      add_item(KIND_UNKNOWN, 4'd15, 32'hffffffff);
      add_item(cdqm_pkg::KIND_CONSUME, 4'd0, 32'h12345678);
      add_item(cdqm_pkg::KIND_CONSUME, 4'd5, 32'h0);
      add_item(cdqm_pkg::KIND_PRODUCE, 4'd15, 32'h7fffffff);
      add_item(cdqm_pkg::KIND_PRODUCE, 4'd9, 32'h80000000);
      add_item(cdqm_pkg::KIND_PRODUCE, 4'd9, 32'h1);
      add_item(cdqm_pkg::KIND_CONSUME, 4'd0, 32'h0);
      add_item(cdqm_pkg::KIND_COMBINE, 4'd7, 32'hdeadbeef);
      add_item(cdqm_pkg::KIND_CONSUME, 4'd3, 32'h0);
      add_item(cdqm_pkg::KIND_COMBINE, 4'd0, 32'h0);
      add_item(cdqm_pkg::KIND_PRODUCE, 4'd7, 32'hffffffff);
      add_item(cdqm_pkg::KIND_PRODUCE, 4'd1, 32'h0);
      add_item(cdqm_pkg::KIND_COMBINE, 4'd15, 32'h0);
      add_item(cdqm_pkg::KIND_CONSUME, 4'd15, 32'h0);
      add_item(cdqm_pkg::KIND_CONSUME, 4'd14, 32'h0);
      add_item(cdqm_pkg::KIND_COMBINE, 4'd0, 32'h0);
      add_item(cdqm_pkg::KIND_PRODUCE, 4'd2, 32'h55555555);
      add_item(cdqm_pkg::KIND_PRODUCE, 4'd12, 32'haaaaaaaa);
      add_item(cdqm_pkg::KIND_COMBINE, 4'd0, 32'h0);

      // random rounds: first two phases fill the fifo, last two drain it
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pct[phase];
         recv_stall_pct = recv_pct[phase];
         queued = 0;
         while (queued < 30) queued += add_round(produce_pct[phase]);
         if (phase == 0) holds_asked++;
         while (pend_wr > pend_rd || req_valid || exp_wr > exp_rd)
            @(negedge clock);
      end

      // let any stray record show up before the verdict
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0 && exp_wr == exp_rd) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
